/* rtl/core/tdcs_pkg.sv */
// Shared types, codes and helpers of the tick driven CPU scheduler.
// Used by tdcs_cell, tick_driven_cpu_scheduler_unit and tdcs_chk.
package tdcs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEC,
		ST_UPD,
		ST_EMIT
	} state_t;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_SRTF = 2'd2;

	localparam logic [1:0] FL_NEW    = 2'd0;
	localparam logic [1:0] FL_QUEUED = 2'd1;
	localparam logic [1:0] FL_RAN    = 2'd2;
	localparam logic [1:0] FL_DONE   = 2'd3;

	localparam logic [1:0] EV_IDLE = 2'd0;
	localparam logic [1:0] EV_RUN  = 2'd1;
	localparam logic [1:0] EV_FIN  = 2'd2;
	localparam logic [1:0] EV_ALL  = 2'd3;

	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [15:0] pid;
		logic [15:0] arr;
		logic [15:0] rem;
		logic [31:0] wt;
		logic [31:0] ta;
		logic [31:0] rsp;
		logic [1:0]  flg;
		logic [31:0] qtime;
		logic        qrot;
	} rec_t;

	typedef struct packed {
		logic [1:0]  ev;
		logic [31:0] tnow;
		logic [15:0] ref_pid;
		logic [31:0] sw;
		logic [31:0] sr;
		logic [31:0] st;
		logic [31:0] bt;
		logic        last;
	} res_t;

	function automatic logic [31:0] inc_sat(input logic [31:0] v);
		inc_sat = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_sat = s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* rtl/core/tdcs_cell.sv */
// One task record of the circulating task ring.
// Depends on tdcs_pkg for the record type.
module tdcs_cell (
	input  logic          clk,
	input  logic          shift,
	input  tdcs_pkg::rec_t nxt,
	input  logic          ld,
	input  tdcs_pkg::rec_t ld_rec,
	output tdcs_pkg::rec_t rec
);

	tdcs_pkg::rec_t rec_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= nxt;
		end else if (ld) begin
			rec_q <= ld_rec;
		end
	end

	assign rec = rec_q;

endmodule

/* rtl/core/tick_driven_cpu_scheduler_unit.sv */
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser opcode, s_tdata task record
// m        out  m_tvalid/m_tready  m_tuser event, m_tdata result, m_tlast last of run
// cfg      in   cfg_we             cfg_idx register, cfg_data value
// A tick rotates the task ring once to select a task and once to update the
// counters, one entry per cycle through the head unit. The all-done tick
// rotates the ring only once, for the scan.
// Reset clears control state; records are undefined until loaded.
// Results wait in a two-word output buffer; a new item is taken while it drains,
// and the next tick holds in its last cycle until the buffer is empty.
// Depends on tdcs_pkg and tdcs_cell.
module tick_driven_cpu_scheduler_unit #(
	parameter int MAX_TASKS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // task_id, arrive_at, burst_len
	input  logic         s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,   // time_now, task_ref, sum_wait, sum_response,
	                                // sum_turnaround, busy_total
	output logic [1:0]   m_tuser,   // event_res
	output logic         m_tlast,   // last_of_run
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [7:0]   cfg_data
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int KW = 65 + IW;

	tdcs_pkg::state_t state_q, state_d;
	tdcs_pkg::rec_t   ring [MAX_TASKS];
	tdcs_pkg::rec_t   proc_rec, ld_rec, hd;

	logic [IW-1:0] ptr_q;
	logic [CW-1:0] loaded_q;
	logic [31:0]   time_q, busy_q;
	logic [7:0]    slice_q, tq_q;
	logic [1:0]    mode_q;
	logic          pend_q;
	logic [31:0]   sw_q, sr_q, st_q;
	logic          have1_q, have2_q;
	logic [KW-1:0] k1_q, k2_q;
	logic [15:0]   p1_q, p2_q, r1_q, r2_q;
	logic [IW-1:0] sel_idx_q, rot_idx_q;
	logic          rot_q, found_q;
	tdcs_pkg::res_t res0_q, res1_q, ob0_q, ob1_q;
	logic [1:0]    nres_q, obn_q;
	tdcs_pkg::res_t res0_d, res1_d;
	logic [1:0]    nres_d;

	logic          shift, load_en, last_ptr, v, cand, lt1, lt2;
	logic [KW-1:0] ck;
	logic [32:0]   hi;
	logic [7:0]    qnt, sl;
	logic          rot, fin;
	logic [15:0]   spid, srem;
	logic [KW-1:0] skey;

	assign s_tready = (state_q == tdcs_pkg::ST_IDLE);
	assign shift    = (state_q == tdcs_pkg::ST_SCAN) || (state_q == tdcs_pkg::ST_UPD);
	assign load_en  = s_tvalid && s_tready && (s_tuser == tdcs_pkg::OP_LOAD)
	                  && (loaded_q < CW'(MAX_TASKS));
	assign last_ptr = (ptr_q == IW'(MAX_TASKS - 1));
	assign v        = (CW'(ptr_q) < loaded_q);
	assign hd       = ring[0];

	always_comb begin
		ld_rec       = '0;
		ld_rec.pid   = s_tdata[15:0];
		ld_rec.arr   = s_tdata[31:16];
		ld_rec.rem   = s_tdata[47:32];
		ld_rec.flg   = (s_tdata[47:32] == 16'd0) ? tdcs_pkg::FL_DONE : tdcs_pkg::FL_NEW;
	end

	genvar k;
	generate
		for (k = 0; k < MAX_TASKS; k++) begin : g_cell
			tdcs_cell u_cell (
				.clk    (clk),
				.shift  (shift),
				.nxt    ((k == MAX_TASKS - 1) ? proc_rec : ring[(k + 1) % MAX_TASKS]),
				.ld     (load_en && (loaded_q[IW-1:0] == IW'(k))),
				.ld_rec (ld_rec),
				.rec    (ring[k])
			);
		end
	endgenerate

	// head unit: enqueue, candidate key, counter update
	always_comb begin
		proc_rec = hd;
		if (state_q == tdcs_pkg::ST_SCAN) begin
			if (v && hd.flg == tdcs_pkg::FL_NEW && {16'd0, hd.arr} <= time_q) begin
				proc_rec.flg   = tdcs_pkg::FL_QUEUED;
				proc_rec.qtime = time_q;
				proc_rec.qrot  = 1'b0;
			end
		end else begin
			if (v && (hd.flg == tdcs_pkg::FL_QUEUED || hd.flg == tdcs_pkg::FL_RAN)) begin
				proc_rec.ta = tdcs_pkg::inc_sat(hd.ta);
				if (found_q && ptr_q == sel_idx_q) begin
					proc_rec.flg = (hd.rem == 16'd1) ? tdcs_pkg::FL_DONE : tdcs_pkg::FL_RAN;
					proc_rec.rem = hd.rem - 16'd1;
				end else begin
					proc_rec.wt = tdcs_pkg::inc_sat(hd.wt);
					if (hd.flg == tdcs_pkg::FL_QUEUED) begin
						proc_rec.rsp = tdcs_pkg::inc_sat(hd.rsp);
					end
				end
			end
			if (v && rot_q && ptr_q == rot_idx_q) begin
				proc_rec.qtime = time_q;
				proc_rec.qrot  = 1'b1;
			end
		end
		case (mode_q)
			tdcs_pkg::POL_RR:   hi = {proc_rec.qtime, proc_rec.qrot};
			tdcs_pkg::POL_SRTF: hi = {17'd0, proc_rec.rem};
			default:            hi = 33'd0;
		endcase
		ck   = {hi, proc_rec.arr, proc_rec.pid, ptr_q};
		cand = v && (proc_rec.flg == tdcs_pkg::FL_QUEUED || proc_rec.flg == tdcs_pkg::FL_RAN);
		lt1  = !have1_q || (ck < k1_q);
		lt2  = !have2_q || (ck < k2_q);
	end

	// selection decision after the scan
	always_comb begin
		qnt  = (tq_q == 8'd0) ? 8'd1 : tq_q;
		rot  = (mode_q == tdcs_pkg::POL_RR) && have1_q && (slice_q >= qnt);
		skey = (rot && have2_q) ? k2_q : k1_q;
		spid = (rot && have2_q) ? p2_q : p1_q;
		srem = (rot && have2_q) ? r2_q : r1_q;
		fin  = have1_q && (srem == 16'd1);
		sl   = rot ? 8'd0 : slice_q;
		if (have1_q && sl != 8'd255) begin
			sl = sl + 8'd1;
		end
		if (fin) begin
			sl = 8'd0;
		end
	end

	always_comb begin
		res0_d      = '0;
		res1_d      = '0;
		res0_d.tnow = time_q;
		res1_d.tnow = time_q;
		res0_d.last = 1'b1;
		nres_d      = 2'd1;
		if (!pend_q) begin
			res0_d.ev = tdcs_pkg::EV_ALL;
			res0_d.sw = sw_q;
			res0_d.sr = sr_q;
			res0_d.st = st_q;
			res0_d.bt = busy_q;
		end else if (have1_q) begin
			res0_d.ev      = tdcs_pkg::EV_RUN;
			res0_d.ref_pid = spid;
			res0_d.last    = !fin;
			res1_d.ev      = tdcs_pkg::EV_FIN;
			res1_d.ref_pid = spid;
			res1_d.last    = 1'b1;
			nres_d         = fin ? 2'd2 : 2'd1;
		end else begin
			res0_d.ev = tdcs_pkg::EV_IDLE;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tdcs_pkg::ST_IDLE: begin
				if (s_tvalid && s_tuser == tdcs_pkg::OP_TICK) begin
					state_d = tdcs_pkg::ST_SCAN;
				end
			end
			tdcs_pkg::ST_SCAN: begin
				if (last_ptr) begin
					state_d = tdcs_pkg::ST_DEC;
				end
			end
			tdcs_pkg::ST_DEC: begin
				state_d = pend_q ? tdcs_pkg::ST_UPD : tdcs_pkg::ST_EMIT;
			end
			tdcs_pkg::ST_UPD: begin
				if (last_ptr) begin
					state_d = tdcs_pkg::ST_EMIT;
				end
			end
			tdcs_pkg::ST_EMIT: begin
				if (obn_q == 2'd0) begin
					state_d = tdcs_pkg::ST_IDLE;
				end
			end
			default: state_d = tdcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			loaded_q  <= '0;
			time_q    <= '0;
			busy_q    <= '0;
			slice_q   <= '0;
			tq_q      <= 8'd1;
			mode_q    <= tdcs_pkg::POL_FCFS;
			pend_q    <= 1'b0;
			sw_q      <= '0;
			sr_q      <= '0;
			st_q      <= '0;
			have1_q   <= 1'b0;
			have2_q   <= 1'b0;
			k1_q      <= '0;
			k2_q      <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
			r1_q      <= '0;
			r2_q      <= '0;
			sel_idx_q <= '0;
			rot_idx_q <= '0;
			rot_q     <= 1'b0;
			found_q   <= 1'b0;
			res0_q    <= '0;
			res1_q    <= '0;
			nres_q    <= '0;
			ob0_q     <= '0;
			ob1_q     <= '0;
			obn_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == tdcs_pkg::REG_POLICY) begin
					mode_q <= cfg_data[1:0];
				end else begin
					tq_q <= cfg_data;
				end
			end
			if (load_en) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (m_tvalid && m_tready) begin
				ob0_q <= ob1_q;
				obn_q <= obn_q - 2'd1;
			end
			case (state_q)
				tdcs_pkg::ST_IDLE: begin
					ptr_q   <= '0;
					pend_q  <= 1'b0;
					sw_q    <= '0;
					sr_q    <= '0;
					st_q    <= '0;
					have1_q <= 1'b0;
					have2_q <= 1'b0;
				end
				tdcs_pkg::ST_SCAN: begin
					ptr_q <= last_ptr ? '0 : ptr_q + IW'(1);
					if (v) begin
						sw_q <= tdcs_pkg::add_sat(sw_q, hd.wt);
						sr_q <= tdcs_pkg::add_sat(sr_q, hd.rsp);
						st_q <= tdcs_pkg::add_sat(st_q, hd.ta);
						if (hd.flg != tdcs_pkg::FL_DONE) begin
							pend_q <= 1'b1;
						end
					end
					if (cand) begin
						if (lt1) begin
							have1_q <= 1'b1;
							k1_q    <= ck;
							p1_q    <= proc_rec.pid;
							r1_q    <= proc_rec.rem;
							have2_q <= have1_q;
							k2_q    <= k1_q;
							p2_q    <= p1_q;
							r2_q    <= r1_q;
						end else if (lt2) begin
							have2_q <= 1'b1;
							k2_q    <= ck;
							p2_q    <= proc_rec.pid;
							r2_q    <= proc_rec.rem;
						end
					end
				end
				tdcs_pkg::ST_DEC: begin
					res0_q <= res0_d;
					res1_q <= res1_d;
					nres_q <= nres_d;
					if (pend_q) begin
						found_q   <= have1_q;
						rot_q     <= rot;
						rot_idx_q <= k1_q[IW-1:0];
						sel_idx_q <= skey[IW-1:0];
						if (mode_q == tdcs_pkg::POL_RR) begin
							slice_q <= sl;
						end
						if (have1_q) begin
							busy_q <= tdcs_pkg::inc_sat(busy_q);
						end
					end
				end
				tdcs_pkg::ST_UPD: begin
					ptr_q <= last_ptr ? '0 : ptr_q + IW'(1);
					if (last_ptr) begin
						time_q <= tdcs_pkg::inc_sat(time_q);
					end
				end
				tdcs_pkg::ST_EMIT: begin
					if (obn_q == 2'd0) begin
						ob0_q <= res0_q;
						ob1_q <= res1_q;
						obn_q <= nres_q;
					end
				end
				default: ptr_q <= '0;
			endcase
		end
	end

	assign m_tvalid = (obn_q != 2'd0);
	assign m_tdata  = {ob0_q.bt, ob0_q.st, ob0_q.sr, ob0_q.sw, ob0_q.ref_pid, ob0_q.tnow};
	assign m_tuser  = ob0_q.ev;
	assign m_tlast  = ob0_q.last;

endmodule

/* rtl/core/tdcs_chk.sv */
// Port level checks of the scheduler result stream, bound to the top level.
// Depends on tdcs_pkg and tick_driven_cpu_scheduler_unit.
module tdcs_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	ap_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	ap_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result word changed while stalled");

	ap_fin_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
		&& m_tuser == tdcs_pkg::EV_FIN && m_tdata[47:32] == $past(m_tdata[47:32]))
		else $error("running word not followed by finish of same task");

	ap_zero_sums: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != tdcs_pkg::EV_ALL |-> m_tdata[175:48] == '0)
		else $error("totals on a non-summary word");

	ap_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tdcs_pkg::EV_ALL || m_tuser == tdcs_pkg::EV_IDLE
		|| m_tuser == tdcs_pkg::EV_FIN) |-> m_tlast)
		else $error("single result word without last");

endmodule

bind tick_driven_cpu_scheduler_unit tdcs_chk u_tdcs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
